@@ design/dda_pkg.sv @@
package dda_pkg;

    // Widths fixed by the interface.
    localparam int PIX_BITS      = 14;
    localparam int CFG_BITS      = 12;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // Defaults for the top-level parameters.
    localparam int COORD_BITS_DEF = 13;
    localparam int FRAC_BITS_DEF  = 16;

    // Register reset values.
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

    // Register indexes, taken from paddr[2].
    localparam logic REG_CANVAS_WIDTH  = 1'b0;
    localparam logic REG_CANVAS_HEIGHT = 1'b1;

    // Request function codes.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

endpackage

@@ design/dda_divider.sv @@
module dda_divider #(
    parameter int NUM_BITS = 30,
    parameter int DEN_BITS = 13,
    parameter int QUO_BITS = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [QUO_BITS-1:0] o_quo
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_num;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS-1:0] r_rem;
    logic [QUO_BITS-1:0] r_quo;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_done;

    logic [DEN_BITS:0]   w_trial;
    logic [DEN_BITS:0]   w_diff;
    logic                w_ge;
    logic [DEN_BITS-1:0] w_rem_next;

    // One restoring step per cycle: bring down the next dividend bit and
    // subtract the divisor when it fits.
    assign w_trial    = {r_rem, r_num[NUM_BITS-1]};
    assign w_ge       = (w_trial >= {1'b0, r_den});
    assign w_diff     = w_trial - {1'b0, r_den};
    assign w_rem_next = w_ge ? w_diff[DEN_BITS-1:0] : w_trial[DEN_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= CNT_BITS'(NUM_BITS);
            end else if (r_cnt != '0) begin
                r_num <= {r_num[NUM_BITS-2:0], 1'b0};
                r_rem <= w_rem_next;
                // The quotient is known to fit, so upper bits simply fall off.
                r_quo <= {r_quo[QUO_BITS-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ design/dda_line_rasterizer.sv @@
// DDA line generator. A load request (func 0) takes two endpoints in
// centre-origin coordinates, maps them to screen space and computes the
// per-step increments with a shared bit-serial divider; the block is not
// ready until the divisions for x and y are done; no division runs when
// the endpoints are equal. Each step request (func 1) then returns one
// pixel in the following cycle, so steps run at one per clock while the
// output side keeps up; a line yields L+1 pixels and the final one has
// last set. Step requests while no line is active return nothing. The
// canvas size registers sit at byte addresses 0 and 4 and should only be
// written while the block is idle.
module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_func,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,

    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [PIX_BITS-1:0]   o_pixel_x,
    output logic signed [PIX_BITS-1:0]   o_pixel_y,
    output logic                         o_visible,
    output logic                         o_last,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_BITS-1:0]     paddr,
    input  logic [APB_DATA_BITS-1:0]     pwdata,
    output logic [APB_DATA_BITS-1:0]     prdata,
    output logic                         pready
);

    localparam int SCR_BITS = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;
    localparam int POS_BITS = SCR_BITS + FRAC_BITS;
    localparam int DLT_BITS = COORD_BITS + 1;
    localparam int LEN_BITS = COORD_BITS;
    localparam int NUM_BITS = COORD_BITS + FRAC_BITS + 1;
    localparam int QUO_BITS = FRAC_BITS + 1;
    localparam int INC_BITS = FRAC_BITS + 2;
    localparam int RND_BITS = SCR_BITS + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_X,
        S_DIV_Y
    } t_state;

    t_state                      r_state;
    logic [CFG_BITS-1:0]         r_canvas_width;
    logic [CFG_BITS-1:0]         r_canvas_height;
    logic                        r_busy;
    logic signed [POS_BITS-1:0]  r_pos_x;
    logic signed [POS_BITS-1:0]  r_pos_y;
    logic signed [INC_BITS-1:0]  r_inc_x;
    logic signed [INC_BITS-1:0]  r_inc_y;
    logic [LEN_BITS-1:0]         r_steps_left;
    logic [LEN_BITS-1:0]         r_len;
    logic [LEN_BITS-1:0]         r_ady;
    logic                        r_neg_x;
    logic                        r_neg_y;
    logic                        r_div_start;
    logic [NUM_BITS-1:0]         r_div_num;
    logic                        r_o_valid;
    logic signed [PIX_BITS-1:0]  r_pixel_x;
    logic signed [PIX_BITS-1:0]  r_pixel_y;
    logic                        r_visible;
    logic                        r_last;

    logic                        n_div_start;
    logic                        n_o_valid;

    logic                        w_take;
    logic                        w_emit;
    logic                        w_cfg_wr;
    logic signed [SCR_BITS-1:0]  w_hw;
    logic signed [SCR_BITS-1:0]  w_hh;
    logic signed [SCR_BITS-1:0]  w_sx;
    logic signed [SCR_BITS-1:0]  w_sy;
    logic signed [DLT_BITS-1:0]  w_dx;
    logic signed [DLT_BITS-1:0]  w_dy;
    logic [DLT_BITS-1:0]         w_adx_full;
    logic [DLT_BITS-1:0]         w_ady_full;
    logic [LEN_BITS-1:0]         w_adx;
    logic [LEN_BITS-1:0]         w_ady;
    logic [LEN_BITS-1:0]         w_len;
    logic [NUM_BITS-1:0]         w_num_x;
    logic [NUM_BITS-1:0]         w_num_y;
    logic                        w_div_done;
    logic [QUO_BITS-1:0]         w_div_quo;
    logic signed [INC_BITS-1:0]  w_quo_ext;
    logic [POS_BITS-1:0]         w_mag_x;
    logic [POS_BITS-1:0]         w_mag_y;
    logic [POS_BITS-1:0]         w_sum_x;
    logic [POS_BITS-1:0]         w_sum_y;
    logic [RND_BITS-1:0]         w_rmag_x;
    logic [RND_BITS-1:0]         w_rmag_y;
    logic signed [RND_BITS-1:0]  w_px;
    logic signed [RND_BITS-1:0]  w_py;
    logic signed [RND_BITS-1:0]  w_lim_x;
    logic signed [RND_BITS-1:0]  w_lim_y;
    logic                        w_vis;

    assign w_take   = i_valid && o_ready;
    assign w_emit   = w_take && (i_func == FUNC_STEP) && r_busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // Screen mapping of the start point, with truncated half sizes.
    assign w_hw = signed'({{(SCR_BITS-CFG_BITS+1){1'b0}}, r_canvas_width[CFG_BITS-1:1]});
    assign w_hh = signed'({{(SCR_BITS-CFG_BITS+1){1'b0}}, r_canvas_height[CFG_BITS-1:1]});
    assign w_sx = SCR_BITS'(i_start_x) + w_hw;
    assign w_sy = w_hh - SCR_BITS'(i_start_y);

    // The centring offsets cancel in the deltas; y points down on screen.
    assign w_dx = DLT_BITS'(i_end_x) - DLT_BITS'(i_start_x);
    assign w_dy = DLT_BITS'(i_start_y) - DLT_BITS'(i_end_y);
    assign w_adx_full = w_dx[DLT_BITS-1] ? DLT_BITS'(-w_dx) : DLT_BITS'(w_dx);
    assign w_ady_full = w_dy[DLT_BITS-1] ? DLT_BITS'(-w_dy) : DLT_BITS'(w_dy);
    assign w_adx = w_adx_full[LEN_BITS-1:0];
    assign w_ady = w_ady_full[LEN_BITS-1:0];
    assign w_len = (w_adx >= w_ady) ? w_adx : w_ady;

    // Dividend |delta| * 2^FRAC_BITS + L/2 gives a rounded-to-nearest quotient.
    assign w_num_x = (NUM_BITS'(w_adx) << FRAC_BITS) + NUM_BITS'(w_len >> 1);
    assign w_num_y = (NUM_BITS'(r_ady) << FRAC_BITS) + NUM_BITS'(r_len >> 1);

    // The divider starts after a load of a non-empty line and again for y.
    assign n_div_start = (w_take && (i_func == FUNC_LOAD) && (w_len != '0)) ||
                         ((r_state == S_DIV_X) && w_div_done);
    assign n_o_valid   = w_emit || (r_o_valid && !i_ready);

    dda_divider #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (LEN_BITS),
        .QUO_BITS (QUO_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_len),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign w_quo_ext = signed'({1'b0, w_div_quo});

    // Round half away from zero on the magnitude, then restore the sign.
    assign w_mag_x  = r_pos_x[POS_BITS-1] ? POS_BITS'(-r_pos_x) : POS_BITS'(r_pos_x);
    assign w_mag_y  = r_pos_y[POS_BITS-1] ? POS_BITS'(-r_pos_y) : POS_BITS'(r_pos_y);
    assign w_sum_x  = w_mag_x + (POS_BITS'(1) << (FRAC_BITS - 1));
    assign w_sum_y  = w_mag_y + (POS_BITS'(1) << (FRAC_BITS - 1));
    assign w_rmag_x = {1'b0, w_sum_x[POS_BITS-1:FRAC_BITS]};
    assign w_rmag_y = {1'b0, w_sum_y[POS_BITS-1:FRAC_BITS]};
    assign w_px     = r_pos_x[POS_BITS-1] ? signed'(-w_rmag_x) : signed'(w_rmag_x);
    assign w_py     = r_pos_y[POS_BITS-1] ? signed'(-w_rmag_y) : signed'(w_rmag_y);

    assign w_lim_x = signed'({{(RND_BITS-CFG_BITS){1'b0}}, r_canvas_width});
    assign w_lim_y = signed'({{(RND_BITS-CFG_BITS){1'b0}}, r_canvas_height});
    assign w_vis   = !w_px[RND_BITS-1] && (w_px <= w_lim_x) &&
                     !w_py[RND_BITS-1] && (w_py <= w_lim_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_busy          <= 1'b0;
            r_div_start     <= 1'b0;
            r_o_valid       <= 1'b0;
            r_canvas_width  <= WIDTH_RESET;
            r_canvas_height <= HEIGHT_RESET;
        end else begin
            r_div_start <= n_div_start;
            r_o_valid   <= n_o_valid;

            if (w_cfg_wr) begin
                case (paddr[2])
                    REG_CANVAS_WIDTH:  r_canvas_width  <= pwdata[CFG_BITS-1:0];
                    REG_CANVAS_HEIGHT: r_canvas_height <= pwdata[CFG_BITS-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        if (i_func == FUNC_LOAD) begin
                            r_pos_x      <= {w_sx, {FRAC_BITS{1'b0}}};
                            r_pos_y      <= {w_sy, {FRAC_BITS{1'b0}}};
                            r_steps_left <= w_len;
                            r_len        <= w_len;
                            r_ady        <= w_ady;
                            r_neg_x      <= w_dx[DLT_BITS-1];
                            r_neg_y      <= w_dy[DLT_BITS-1];
                            r_busy       <= 1'b1;
                            r_inc_x      <= '0;
                            r_inc_y      <= '0;
                            // A zero-length line needs no increments.
                            if (w_len != '0) begin
                                r_div_num <= w_num_x;
                                r_state   <= S_DIV_X;
                            end
                        end else if (r_busy) begin
                            r_pixel_x <= w_px[PIX_BITS-1:0];
                            r_pixel_y <= w_py[PIX_BITS-1:0];
                            r_visible <= w_vis;
                            r_last    <= (r_steps_left == '0);
                            if (r_steps_left == '0) begin
                                r_busy <= 1'b0;
                            end else begin
                                r_pos_x      <= r_pos_x + POS_BITS'(r_inc_x);
                                r_pos_y      <= r_pos_y + POS_BITS'(r_inc_y);
                                r_steps_left <= r_steps_left - 1'b1;
                            end
                        end
                    end
                end
                S_DIV_X: begin
                    if (w_div_done) begin
                        r_inc_x   <= r_neg_x ? -w_quo_ext : w_quo_ext;
                        r_div_num <= w_num_y;
                        r_state   <= S_DIV_Y;
                    end
                end
                S_DIV_Y: begin
                    if (w_div_done) begin
                        r_inc_y <= r_neg_y ? -w_quo_ext : w_quo_ext;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_CANVAS_WIDTH:  prdata = APB_DATA_BITS'(r_canvas_width);
            REG_CANVAS_HEIGHT: prdata = APB_DATA_BITS'(r_canvas_height);
            default:           prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign o_ready   = (r_state == S_IDLE) && (!r_o_valid || i_ready);
    assign o_valid   = r_o_valid;
    assign o_pixel_x = r_pixel_x;
    assign o_pixel_y = r_pixel_y;
    assign o_visible = r_visible;
    assign o_last    = r_last;

endmodule
